// File: src/ffa_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffa_pkg;

  localparam int FUNC_W = 2;
  localparam int SIZE_W = 27;
  localparam int ADDR_W = 32;
  localparam int STAT_W = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [FUNC_W-1:0] FN_ALLOC   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_REALLOC = 2'd2;
  localparam logic [FUNC_W-1:0] FN_NONE    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE = 3'd1;
  localparam logic [STAT_W-1:0] ST_HEAP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_TABLE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNKNOWN  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT  = 1'd1;

  localparam logic [SIZE_W-1:0] RESET_MAX_REQUEST = 27'd100000000;

  // One row of the block table.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] dsize;
    logic              is_free;
  } ent_t;

endpackage

// File: src/ffa_if.sv
// Handshake channels of the allocator: command, response and config write.
// Depends on ffa_pkg.
interface ffa_cmd_if import ffa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] data_addr;
  modport source (output valid, func, req_size, data_addr, input ready);
  modport sink   (input valid, func, req_size, data_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; #(parameter int CNT_W = 7) ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] result_addr;
  logic [CNT_W-1:0]  free_block_count;
  logic [31:0]       free_byte_count;
  logic [CNT_W-1:0]  block_count;
  logic [31:0]       total_byte_count;
  logic [31:0]       meta_byte_count;
  modport source (output valid, status, result_addr, free_block_count, free_byte_count,
                  block_count, total_byte_count, meta_byte_count, input ready);
  modport sink   (input valid, status, result_addr, free_block_count, free_byte_count,
                  block_count, total_byte_count, meta_byte_count, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/ffa_mem.sv
// Block table storage: one write port, one read port with registered data.
// Depends on ffa_pkg.
module ffa_mem import ffa_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  ent_t          wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output ent_t          rdata
);
  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: src/first_fit_block_allocator.sv
// First-fit block allocator top level: sequencer, statistics and config.
// Depends on ffa_pkg, ffa_if (channels) and ffa_mem (block table).
//
//   channel | dir | contents
//   --------+-----+------------------------------------------------------
//   cmd     | in  | func, req_size, data_addr
//   rsp     | out | status, result_addr, block/byte statistics
//   cfg     | in  | index (0 max_request, 1 heap_limit), data
//
// An item walks the table one row per cycle through the read port; a realloc
// that moves runs a lookup walk and then a fit walk. The table memory's single
// read port sets this pace. Reset (rst, synchronous) empties the table at once;
// table rows need no clearing since only rows below the block count are read.
// A finished beat waits in the response register; the next command is taken
// while it waits, and only a second finished result stalls behind it.
module first_fit_block_allocator import ffa_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 40
) (
  input  logic       clk,
  input  logic       rst,
  ffa_cmd_if.sink    cmd,
  ffa_rsp_if.source  rsp,
  ffa_cfg_if.sink    cfg
);
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  // byte accumulators never wrap: MAX_BLOCKS rows of at most 27 bits
  localparam int AW = SIZE_W + CW;
  localparam int SW = (AW > 32) ? AW : 33;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_REL  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  localparam logic M_FIND = 1'b0;
  localparam logic M_FIT  = 1'b1;

  // config registers
  logic [SIZE_W-1:0] max_request;
  logic [ADDR_W-1:0] heap_limit;

  // control state
  logic [2:0]        state;
  logic              mode;
  logic [FUNC_W-1:0] op;
  logic [SIZE_W-1:0] size;
  logic [ADDR_W-1:0] addr;
  logic [CW-1:0]     idx;
  logic              rd_pend;
  logic [IW-1:0]     rd_idx;
  logic [STAT_W-1:0] res_status;
  logic [ADDR_W-1:0] res_addr;

  // block found by the lookup walk, released after a moving realloc
  ent_t              old_ent;
  logic [IW-1:0]     old_idx;

  // heap statistics
  logic [CW-1:0]     used;
  logic [ADDR_W-1:0] brk;
  logic [CW-1:0]     free_cnt;
  logic [AW-1:0]     free_bytes;
  logic [AW-1:0]     all_bytes;

  // table port
  logic              we;
  logic [IW-1:0]     waddr;
  ent_t              wdata;
  logic              re;
  ent_t              rdata;

  logic              hit;
  logic [ADDR_W-1:0] rd_daddr;
  logic [ADDR_W+1:0] nb;
  logic              bad_cmd;
  logic              out_free;

  ffa_mem #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (idx[IW-1:0]),
    .rdata (rdata)
  );

  function automatic logic [31:0] sat32(input logic [AW-1:0] v);
    logic [SW-1:0] e;
    e = SW'(v);
    return (e > SW'(33'h0FFFFFFFF)) ? 32'hFFFFFFFF : e[31:0];
  endfunction

  assign rd_daddr = rdata.start + ADDR_W'(HEADER_BYTES);
  assign nb       = {2'b00, brk} + (ADDR_W+2)'(size) + (ADDR_W+2)'(HEADER_BYTES);
  assign hit      = rd_pend && ((mode == M_FIT) ? (rdata.is_free && rdata.cap >= size)
                                                : (rd_daddr == addr));
  assign bad_cmd  = (cmd.req_size == '0) || (cmd.req_size >= max_request);
  assign out_free = !rsp.valid || rsp.ready;

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign re        = (state == S_SCAN) && !hit && (idx < used);

  // table writes: a fit or append in the walk, a free in the walk, or the
  // release of the old block after a moving realloc
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    if (state == S_SCAN) begin
      if (hit && mode == M_FIT) begin
        we          = 1'b1;
        wdata.dsize = size;
        wdata.is_free = 1'b0;
      end else if (hit && op == FN_FREE) begin
        we            = 1'b1;
        wdata.dsize   = rdata.cap;
        wdata.is_free = 1'b1;
      end else if (!hit && !(idx < used) && !rd_pend && mode == M_FIT &&
                   used != CW'(MAX_BLOCKS) && nb <= {2'b00, heap_limit}) begin
        we            = 1'b1;
        waddr         = used[IW-1:0];
        wdata.start   = brk;
        wdata.cap     = size;
        wdata.dsize   = size;
        wdata.is_free = 1'b0;
      end
    end else if (state == S_REL) begin
      we            = 1'b1;
      waddr         = old_idx;
      wdata         = old_ent;
      wdata.dsize   = old_ent.cap;
      wdata.is_free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_request <= RESET_MAX_REQUEST;
      heap_limit  <= '1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_MAX_REQUEST: max_request <= cfg.data[SIZE_W-1:0];
        REG_HEAP_LIMIT:  heap_limit  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_FIND;
      rd_pend    <= 1'b0;
      idx        <= '0;
      used       <= '0;
      brk        <= '0;
      free_cnt   <= '0;
      free_bytes <= '0;
      all_bytes  <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      // S_DONE reloads the response register itself when it is free
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op         <= cmd.func;
            size       <= cmd.req_size;
            addr       <= cmd.data_addr;
            res_status <= ST_OK;
            res_addr   <= '0;
            idx        <= '0;
            rd_pend    <= 1'b0;
            mode       <= (cmd.func == FN_ALLOC) ? M_FIT : M_FIND;
            unique case (cmd.func) inside
              FN_ALLOC, FN_REALLOC: begin
                if (bad_cmd) begin
                  res_status <= ST_BAD_SIZE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCAN;
                end
              end
              FN_FREE: state <= S_SCAN;
              default: state <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            rd_pend <= 1'b0;
            if (mode == M_FIT) begin
              free_cnt   <= free_cnt - 1'b1;
              free_bytes <= free_bytes - AW'(rdata.cap);
              res_addr   <= rd_daddr;
              state      <= (op == FN_REALLOC) ? S_REL : S_DONE;
            end else if (op == FN_FREE) begin
              if (!rdata.is_free) begin
                free_cnt   <= free_cnt + 1'b1;
                free_bytes <= free_bytes + AW'(rdata.cap);
              end
              state <= S_DONE;
            end else begin
              old_ent <= rdata;
              old_idx <= rd_idx;
              if (rdata.dsize >= size) begin
                res_addr <= addr;
                state    <= S_DONE;
              end else begin
                // restart the walk looking for a fitting block
                mode <= M_FIT;
                idx  <= '0;
              end
            end
          end else if (idx < used) begin
            rd_pend <= 1'b1;
            rd_idx  <= idx[IW-1:0];
            idx     <= idx + 1'b1;
          end else if (rd_pend) begin
            rd_pend <= 1'b0;
          end else if (mode == M_FIND) begin
            res_status <= ST_UNKNOWN;
            state      <= S_DONE;
          end else if (used == CW'(MAX_BLOCKS)) begin
            res_status <= ST_TABLE;
            state      <= S_DONE;
          end else if (nb > {2'b00, heap_limit}) begin
            res_status <= ST_HEAP;
            state      <= S_DONE;
          end else begin
            // append at the break
            used      <= used + 1'b1;
            brk       <= nb[ADDR_W-1:0];
            all_bytes <= all_bytes + AW'(size);
            res_addr  <= brk + ADDR_W'(HEADER_BYTES);
            state     <= (op == FN_REALLOC) ? S_REL : S_DONE;
          end
        end
        S_REL: begin
          if (!old_ent.is_free) begin
            free_cnt   <= free_cnt + 1'b1;
            free_bytes <= free_bytes + AW'(old_ent.cap);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            rsp.valid            <= 1'b1;
            rsp.status           <= res_status;
            rsp.result_addr      <= res_addr;
            rsp.free_block_count <= free_cnt;
            rsp.free_byte_count  <= sat32(free_bytes);
            rsp.block_count      <= used;
            rsp.total_byte_count <= sat32(all_bytes);
            rsp.meta_byte_count  <= 32'(32'(used) * 32'(HEADER_BYTES));
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: test/first_fit_block_allocator_tb.sv
// Self-checking testbench for first_fit_block_allocator: directed and random
// allocate/free/realloc beats checked against an in-bench block table model.
// Depends on ffa_pkg and the ffa_if channel interfaces.
module first_fit_block_allocator_tb;
  import ffa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam int HDR = 40;
  localparam int DRAIN = 2 * NBLK + 40;   // worst item latency plus margin
  localparam int LIMIT = 1000000;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                pick;    // resolve addr to a live block when driven
  } cmd_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        free_blks;
    logic [31:0]       free_bytes;
    logic [6:0]        blks;
    logic [31:0]       all_bytes;
    logic [31:0]       meta_bytes;
  } rsp_t;

  logic clk = 0;
  logic rst = 1;

  ffa_cmd_if cmd_ch ();
  ffa_rsp_if #(.CNT_W(7)) rsp_ch ();
  ffa_cfg_if cfg_ch ();

  first_fit_block_allocator dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch.sink), .rsp(rsp_ch.source), .cfg(cfg_ch.sink)
  );

  // Shadow of the block table and its registers.
  logic [ADDR_W-1:0] tbl_start [NBLK];
  logic [SIZE_W-1:0] tbl_cap   [NBLK];
  logic [SIZE_W-1:0] tbl_dsize [NBLK];
  bit                tbl_free  [NBLK];
  int unsigned       tbl_used = 0;
  logic [31:0]       brk_off = '0;
  logic [SIZE_W-1:0] max_req = RESET_MAX_REQUEST;
  logic [31:0]       heap_lim = 32'hFFFF_FFFF;

  cmd_t pending_cmds [$];
  rsp_t expected_rsps [$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned errors = 0;
  bit quiet = 0;          // no idling in the closing stretch
  bit pressure_go = 0;    // request a long response hold-off
  cmd_t cur;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor: first-fit search, else append at the break.
  // ---------------------------------------------------------------------
  function automatic logic [STAT_W-1:0] fit_or_append(input logic [SIZE_W-1:0] s,
                                                      output logic [ADDR_W-1:0] a);
    logic [33:0] nb;
    a = '0;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_free[i] && tbl_cap[i] >= s) begin
        tbl_free[i] = 0;
        tbl_dsize[i] = s;
        a = tbl_start[i] + HDR;
        return ST_OK;
      end
    end
    if (tbl_used >= NBLK) return ST_TABLE;
    nb = {2'b0, brk_off} + s + HDR;
    if (nb > {2'b0, heap_lim}) return ST_HEAP;
    tbl_start[tbl_used] = brk_off;
    tbl_cap[tbl_used] = s;
    tbl_dsize[tbl_used] = s;
    tbl_free[tbl_used] = 0;
    tbl_used++;
    brk_off = nb[31:0];
    a = tbl_start[tbl_used-1] + HDR;
    return ST_OK;
  endfunction

  function automatic int lookup_block(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < tbl_used; i++)
      if (tbl_start[i] + 32'(HDR) == a) return i;
    return -1;
  endfunction

  function automatic rsp_t apply_cmd(input cmd_t c);
    rsp_t r;
    int idx;
    logic [ADDR_W-1:0] na;
    logic [63:0] fb, ab;
    bit bad;
    r.status = ST_OK;
    r.addr = '0;
    fb = 0;
    ab = 0;
    bad = (c.size == 0) || (c.size >= max_req);
    case (c.func)
      FN_ALLOC: begin
        if (bad) r.status = ST_BAD_SIZE;
        else r.status = fit_or_append(c.size, r.addr);
      end
      FN_FREE: begin
        idx = lookup_block(c.addr);
        if (idx < 0) r.status = ST_UNKNOWN;
        else begin
          tbl_free[idx] = 1;
          tbl_dsize[idx] = tbl_cap[idx];
        end
      end
      FN_REALLOC: begin
        if (bad) r.status = ST_BAD_SIZE;
        else begin
          idx = lookup_block(c.addr);
          if (idx < 0) r.status = ST_UNKNOWN;
          else if (tbl_dsize[idx] >= c.size) r.addr = c.addr;
          else begin
            r.status = fit_or_append(c.size, na);
            if (r.status == ST_OK) begin
              tbl_free[idx] = 1;
              tbl_dsize[idx] = tbl_cap[idx];
              r.addr = na;
            end
          end
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) r.addr = '0;
    r.free_blks = '0;
    for (int i = 0; i < tbl_used; i++) begin
      ab += tbl_cap[i];
      if (tbl_free[i]) begin
        r.free_blks++;
        fb += tbl_cap[i];
      end
    end
    r.free_bytes = (fb > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : fb[31:0];
    r.all_bytes = (ab > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : ab[31:0];
    r.blks = 7'(tbl_used);
    r.meta_bytes = 32'(tbl_used * HDR);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Command driver: predicts on each accepted beat, then offers the next.
  // ---------------------------------------------------------------------
  int unsigned cmd_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.func <= FN_NONE;
      cmd_ch.req_size <= '0;
      cmd_ch.data_addr <= '0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        expected_rsps.push_back(apply_cmd(cur));
        accepted_cnt++;
        if (!quiet && $urandom_range(0, 3) == 0) cmd_gap = $urandom_range(1, 4);
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_gap > 0 || pending_cmds.size() == 0) begin
          if (cmd_gap > 0) cmd_gap--;
          cmd_ch.valid <= 1'b0;
        end else begin
          cur = pending_cmds.pop_front();
          // Live block picked now, so the table reflects every earlier beat.
          if (cur.pick && tbl_used > 0)
            cur.addr = tbl_start[$urandom_range(0, tbl_used - 1)] + HDR;
          cmd_ch.valid <= 1'b1;
          cmd_ch.func <= cur.func;
          cmd_ch.req_size <= cur.size;
          cmd_ch.data_addr <= cur.addr;
        end
      end
    end
  end

  // Response ready: short random stalls, plus one long hold-off on request.
  int unsigned rsp_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (pressure_go) begin
      pressure_go = 0;
      rsp_stall = 400;
      rsp_ch.ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      rsp_stall = $urandom_range(0, 3);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Response monitor: field-by-field compare with the oldest expectation.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: response beat with none expected, status %0d addr %h",
                 $realtime, rsp_ch.status, rsp_ch.result_addr);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_ch.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, e.status, rsp_ch.status);
          errors++;
        end
        if (rsp_ch.result_addr !== e.addr) begin
          $display("%0t: result_addr exp %h got %h", $realtime, e.addr, rsp_ch.result_addr);
          errors++;
        end
        if (rsp_ch.free_block_count !== e.free_blks) begin
          $display("%0t: free_block_count exp %0d got %0d", $realtime, e.free_blks,
                   rsp_ch.free_block_count);
          errors++;
        end
        if (rsp_ch.free_byte_count !== e.free_bytes) begin
          $display("%0t: free_byte_count exp %0d got %0d", $realtime, e.free_bytes,
                   rsp_ch.free_byte_count);
          errors++;
        end
        if (rsp_ch.block_count !== e.blks) begin
          $display("%0t: block_count exp %0d got %0d", $realtime, e.blks,
                   rsp_ch.block_count);
          errors++;
        end
        if (rsp_ch.total_byte_count !== e.all_bytes) begin
          $display("%0t: total_byte_count exp %0d got %0d", $realtime, e.all_bytes,
                   rsp_ch.total_byte_count);
          errors++;
        end
        if (rsp_ch.meta_byte_count !== e.meta_bytes) begin
          $display("%0t: meta_byte_count exp %0d got %0d", $realtime, e.meta_bytes,
                   rsp_ch.meta_byte_count);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("first_fit_block_allocator_tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------
  task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic [SIZE_W-1:0] s,
                          input logic [ADDR_W-1:0] a, input bit pick);
    cmd_t c;
    c.func = f;
    c.size = s;
    c.addr = a;
    c.pick = pick;
    pending_cmds.push_back(c);
    queued_cnt++;
  endtask

  // Block until every queued beat is taken and answered, then let a
  // no-result walk finish before touching config.
  task automatic drain();
    while (accepted_cnt != queued_cnt || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MAX_REQUEST) max_req = val[SIZE_W-1:0];
    else heap_lim = val;
  endtask

  // Random mix; big selects huge sizes that run the heap out.
  task automatic push_random(input int n, input bit big);
    int r;
    logic [FUNC_W-1:0] f;
    logic [SIZE_W-1:0] s;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      f = (r < 40) ? FN_ALLOC : (r < 65) ? FN_FREE : (r < 92) ? FN_REALLOC : FN_NONE;
      r = $urandom_range(0, 99);
      if (r < 4) s = '0;
      else if (r < 9) s = SIZE_W'($urandom);
      else if (big) s = SIZE_W'($urandom_range(10000000, 134217727));
      else s = SIZE_W'($urandom_range(1, 400));
      if ($urandom_range(0, 9) < 8) push_cmd(f, s, '0, 1);
      else push_cmd(f, s, $urandom, 0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MAX_REQUEST;
    cfg_ch.data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every size rejected; nothing fits the heap.
    write_reg(REG_MAX_REQUEST, 32'd1);
    write_reg(REG_HEAP_LIMIT, 32'd0);
    push_cmd(FN_ALLOC, '0, '0, 0);
    push_cmd(FN_ALLOC, 27'd1, '0, 0);
    push_cmd(FN_REALLOC, 27'd5, '0, 0);
    push_cmd(FN_FREE, '0, '0, 0);            // address zero is never a block
    push_cmd(FN_NONE, '1, '1, 0);
    drain();

    // Widest request limit, zero heap: heap exhausted.
    write_reg(REG_MAX_REQUEST, 32'h7FF_FFFF);
    push_cmd(FN_ALLOC, 27'd1, '0, 0);
    push_cmd(FN_ALLOC, 27'h7FF_FFFE, '0, 0);
    drain();

    // Room for exactly one 60-byte block.
    write_reg(REG_HEAP_LIMIT, 32'd100);
    push_cmd(FN_ALLOC, 27'd60, '0, 0);
    push_cmd(FN_ALLOC, 27'd1, '0, 0);
    push_cmd(FN_REALLOC, 27'd61, 32'd40, 0);  // move fails, old block kept
    push_cmd(FN_REALLOC, 27'd30, 32'd40, 0);  // fits in place
    drain();

    // Default-sized limits, directed special cases.
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_MAX_REQUEST, 32'd100000000);
    push_cmd(FN_ALLOC, 27'd100000000, '0, 0);
    push_cmd(FN_ALLOC, 27'd99999999, '0, 0);
    push_cmd(FN_ALLOC, 27'd10, '0, 0);
    push_cmd(FN_FREE, '0, 32'd40, 0);
    push_cmd(FN_FREE, '0, 32'd40, 0);         // double free
    push_cmd(FN_REALLOC, 27'd50, 32'd40, 0);  // realloc of a free block
    push_cmd(FN_ALLOC, 27'd20, '0, 0);        // first fit reuses block 0
    push_cmd(FN_REALLOC, 27'd500, 32'd140, 0);
    push_cmd(FN_FREE, '0, 32'hFFFF_FFFF, 0);
    push_cmd(FN_REALLOC, 27'd0, 32'd40, 0);
    drain();

    // Random, small sizes, with one long response hold-off.
    write_reg(REG_MAX_REQUEST, 32'd300);
    push_random(150, 0);
    repeat (50) @(posedge clk);
    pressure_go = 1;
    drain();

    // Big sizes drive the break toward the top of the address space.
    write_reg(REG_MAX_REQUEST, 32'h7FF_FFFF);
    push_random(60, 1);
    drain();

    // Fill whatever table space is left, then small random with a
    // tight heap ceiling.
    write_reg(REG_HEAP_LIMIT, brk_off + 32'd3000);
    write_reg(REG_MAX_REQUEST, 32'd1000);
    for (int k = 0; k < 70; k++) push_cmd(FN_ALLOC, 27'd1, '0, 0);
    push_random(60, 0);
    drain();

    // Closing stretch with no idling on either side.
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    quiet = 1;
    push_random(80, 0);
    drain();

    if (errors == 0) $display("first_fit_block_allocator_tb: clean");
    else $display("first_fit_block_allocator_tb: errors");
    $finish;
  end

endmodule
